// ----- sv/prosign_word_substituter_unit_assert.svh -----
// Assertion macros used by the checker of this block.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef PROSIGN_WORD_SUBSTITUTER_UNIT_ASSERT_SVH
`define PROSIGN_WORD_SUBSTITUTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PWS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pws_pkg.sv -----
`timescale 1ns / 1ps

package pws_pkg;

    // Character codes used by the word rules.
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_O      = 8'h4f;
    localparam logic [7:0] SOS_CODE    = 8'h5c;

    // Held word storage and the per-transaction result burst.
    localparam int HELD_DEPTH  = 3;
    localparam int BURST_DEPTH = 4;
    localparam int PAIR_COUNT  = 13;

    // Two-letter prosigns and their substitution codes.
    localparam logic [7:0] PAIR_FIRST [PAIR_COUNT] = '{
        8'h41, 8'h41, 8'h41, 8'h42, 8'h42, 8'h43, 8'h43,
        8'h44, 8'h48, 8'h4b, 8'h4b, 8'h53, 8'h53
    };
    localparam logic [7:0] PAIR_SECOND [PAIR_COUNT] = '{
        8'h41, 8'h52, 8'h53, 8'h4b, 8'h54, 8'h4c, 8'h54,
        8'h4f, 8'h48, 8'h41, 8'h4e, 8'h4b, 8'h4e
    };
    localparam logic [7:0] PAIR_CODE [PAIR_COUNT] = '{
        8'h7e, 8'h5e, 8'h3c, 8'h3e, 8'h5b, 8'h5d, 8'h7b,
        8'h7d, 8'h23, 8'h2a, 8'h24, 8'h7c, 8'h5f
    };

    typedef logic [HELD_DEPTH-1:0][7:0]  held_t;
    typedef logic [BURST_DEPTH-1:0][7:0] burst_bytes_t;

    // One input transaction.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       message_end;
    } item_t;

    // One output transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       out_message_end;
    } result_t;

    // Results produced by one input, handed from the word logic to the output side.
    typedef struct packed {
        burst_bytes_t bytes;
        logic [2:0]   count;
        logic         msg_end;
    } burst_t;

    // Outcome of closing a word: the bytes to send and how many there are.
    typedef struct packed {
        held_t      bytes;
        logic [1:0] count;
    } settle_t;

    // Closes the held word: SOS or a prosign collapses to one code, else release as is.
    function automatic settle_t settle_word(input logic [1:0] cnt, input held_t held);
        settle_t s;
        logic    hit;
        logic [7:0] code;
        hit  = 1'b0;
        code = '0;
        for (int i = 0; i < PAIR_COUNT; i++) begin
            if (held[0] == PAIR_FIRST[i] && held[1] == PAIR_SECOND[i]) begin
                hit  = 1'b1;
                code = PAIR_CODE[i];
            end
        end
        s.bytes = held;
        s.count = cnt;
        if (cnt == 2'd3 && held[0] == CHAR_S && held[1] == CHAR_O && held[2] == CHAR_S) begin
            s.bytes    = '0;
            s.bytes[0] = SOS_CODE;
            s.count    = 2'd1;
        end else if (cnt == 2'd2 && hit) begin
            s.bytes    = '0;
            s.bytes[0] = code;
            s.count    = 2'd1;
        end
        return s;
    endfunction

endpackage

// ----- sv/pws_core.sv -----
`timescale 1ns / 1ps

module pws_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  pws_pkg::item_t item,
    output pws_pkg::burst_t burst
);
    import pws_pkg::*;

    held_t      held_reg;
    held_t      held_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       long_reg;
    logic       long_next;

    // Word rules for one byte: work out the results and the next word state.
    always_comb
    begin
        logic [7:0]   b;
        settle_t      s;
        burst_bytes_t bytes;
        logic [2:0]   n;
        b         = item.in_byte;
        s         = '0;
        bytes     = '0;
        n         = 3'd0;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        long_next = long_reg;
        if (b >= LOWER_A && b <= LOWER_Z) begin
            b = b - CASE_OFFSET;
        end

        if (b == SPACE_CHAR) begin
            // A space closes the word, then goes out itself.
            s = settle_word(cnt_reg, held_reg);
            for (int i = 0; i < HELD_DEPTH; i++) begin
                if (i < int'(s.count)) begin
                    bytes[n[1:0]] = s.bytes[i];
                    n = n + 3'd1;
                end
            end
            bytes[n[1:0]] = b;
            n = n + 3'd1;
            cnt_next  = 2'd0;
            long_next = 1'b0;
        end else if (long_reg) begin
            // Past three bytes the word streams straight through.
            bytes[n[1:0]] = b;
            n = n + 3'd1;
        end else if (cnt_reg != 2'd3) begin
            held_next[cnt_reg] = b;
            cnt_next = cnt_reg + 2'd1;
        end else begin
            // A fourth byte releases the held three and marks the word as long.
            for (int i = 0; i < HELD_DEPTH; i++) begin
                bytes[n[1:0]] = held_reg[i];
                n = n + 3'd1;
            end
            bytes[n[1:0]] = b;
            n = n + 3'd1;
            cnt_next  = 2'd0;
            long_next = 1'b1;
        end

        // The message end closes whatever is still held and restarts the word state.
        if (item.message_end) begin
            s = settle_word(cnt_next, held_next);
            for (int i = 0; i < HELD_DEPTH; i++) begin
                if (i < int'(s.count)) begin
                    bytes[n[1:0]] = s.bytes[i];
                    n = n + 3'd1;
                end
            end
            cnt_next  = 2'd0;
            long_next = 1'b0;
        end

        burst.bytes   = bytes;
        burst.count   = n;
        burst.msg_end = item.message_end;
    end

    // Word state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= 2'd0;
            long_reg <= 1'b0;
        end else if (take) begin
            cnt_reg  <= cnt_next;
            long_reg <= long_next;
        end
    end

    // Held bytes carry no reset; only entries below the count are read.
    always_ff @(posedge clk)
    begin
        if (take) begin
            held_reg <= held_next;
        end
    end

endmodule

// ----- sv/prosign_word_substituter_unit.sv -----
`timescale 1ns / 1ps

// Prosign word substituter.
// Input channel (item_valid, item_stall, item): one text byte per transaction,
// with message_end set on the last byte of a message. Output channel
// (result_valid, result_stall, result): one rewritten byte per transaction.
// run_last marks the last result caused by an input byte; out_message_end
// marks the final result of a message. A byte that is only held back
// produces no result.
// A result caused by an accepted byte is registered in the burst and then in
// the output register before it is offered.
// Throughput: an input producing zero or one result is taken every cycle
// unless the receiver stalls; one producing more (at most four) holds the
// input while the single-result output register drains the result burst.
// Reset clears the word state, the burst and the output register, so the
// next byte starts a new message. When the receiver stalls, the offered
// result holds; once a result waits behind it in the burst, item_stall rises.
module prosign_word_substituter_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pws_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pws_pkg::result_t result
);
    import pws_pkg::*;

    burst_t       burst;
    burst_bytes_t burst_bytes_reg;
    logic [2:0]   burst_rem_reg;
    logic [2:0]   burst_rem_next;
    logic [1:0]   burst_idx_reg;
    logic [1:0]   burst_idx_next;
    logic         burst_end_reg;
    logic         out_valid_reg;
    result_t      out_data_reg;
    logic         take;
    logic         move;

    // A result moves to the output register when it is free or being emptied.
    assign move       = (burst_rem_reg != 3'd0) && (!out_valid_reg || !result_stall);
    assign item_stall = !((burst_rem_reg == 3'd0) || (burst_rem_reg == 3'd1 && move));
    assign take       = item_valid && !item_stall;

    pws_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .burst (burst)
    );

    // Burst bookkeeping: load on a new transaction, step on each move.
    always_comb
    begin
        burst_rem_next = burst_rem_reg;
        burst_idx_next = burst_idx_reg;
        if (move) begin
            burst_rem_next = burst_rem_reg - 3'd1;
            burst_idx_next = burst_idx_reg + 2'd1;
        end
        if (take) begin
            burst_rem_next = burst.count;
            burst_idx_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            burst_rem_reg <= 3'd0;
            burst_idx_reg <= 2'd0;
        end else begin
            burst_rem_reg <= burst_rem_next;
            burst_idx_reg <= burst_idx_next;
        end
    end

    // Burst payload.
    always_ff @(posedge clk)
    begin
        if (take) begin
            burst_bytes_reg <= burst.bytes;
            burst_end_reg   <= burst.msg_end;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (move) begin
            out_valid_reg <= 1'b1;
        end else if (!result_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move) begin
            out_data_reg.out_byte        <= burst_bytes_reg[burst_idx_reg];
            out_data_reg.run_last        <= (burst_rem_reg == 3'd1);
            out_data_reg.out_message_end <= (burst_rem_reg == 3'd1) && burst_end_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

// ----- sv/pws_checker.sv -----
`timescale 1ns / 1ps
`include "prosign_word_substituter_unit_assert.svh"

module pws_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input pws_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input pws_pkg::result_t result
);
    import pws_pkg::*;

    // A stalled result transaction stays offered and unchanged.
    `PWS_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(result), "stalled result changed")

    // The end of a message is always the last result of its input byte.
    `PWS_ASSERT_SAME(a_end_is_last, result_valid && result.out_message_end,
        result.run_last, "message end without run_last")

    // The input is only held off while results are backed up behind the output.
    `PWS_ASSERT_NEXT(a_stall_has_output, item_stall, result_valid,
        "input stalled with no result pending")

    // A message-end byte always gives a result, offered once it has passed the burst and output registers.
    `PWS_ASSERT_NEXT(a_end_gives_result, item_valid && !item_stall && item.message_end,
        ##1 result_valid, "message end produced nothing")

endmodule

bind prosign_word_substituter_unit pws_checker u_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // Character codes the word rules depend on.
    localparam logic [7:0] SPACE_BYTE  = 8'h20;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7a;
    localparam logic [7:0] UPPER_A     = 8'h41;
    localparam logic [7:0] UPPER_Z     = 8'h5a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] LETTER_S    = 8'h53;
    localparam logic [7:0] LETTER_O    = 8'h4f;
    localparam logic [7:0] SOS_SUB     = 8'h5c;
    localparam int         NUM_PROSIGNS = 13;

    // Two-letter prosigns and the single code each one collapses to.
    localparam logic [15:0] PROSIGN_WORDS [NUM_PROSIGNS] = '{
        "AA", "AR", "AS", "BK", "BT", "CL", "CT", "DO", "HH", "KA", "KN", "SK", "SN"
    };
    localparam logic [7:0] PROSIGN_CODES [NUM_PROSIGNS] = '{
        "~", "^", "<", ">", "[", "]", "{", "}", "#", "*", "$", "|", "_"
    };

    // Run shape.
    localparam int TEXT_ITEMS     = 330;
    localparam int MAX_IDLE       = 12;
    localparam int HOLD_OFF_LEN   = 150;
    localparam int SETTLE_CYCLES  = 20;
    localparam int REPORT_LIMIT   = 10;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    pws_pkg::item_t       item;
    logic                 result_valid;
    logic                 result_stall;
    pws_pkg::result_t     result;

    // Receiver-side hold-off request and the no-idle stretch flag.
    bit                   hold_off_req;
    bit                   no_idle;

    pws_pkg::item_t       text_q[$];

    // Tracks the word state of the block and the rewritten bytes still owed.
    class prosign_scoreboard;
        logic [7:0]       held [3];
        int               held_cnt;
        bit               long_word;
        logic [7:0]       burst_q[$];
        pws_pkg::result_t rewritten_q[$];
        int               errors;

        function new();
            held_cnt  = 0;
            long_word = 0;
            errors    = 0;
        endfunction

        function int pending();
            return rewritten_q.size();
        endfunction

        // Settles the held word: SOS or a prosign becomes one code, else it goes out as is.
        function void close_word();
            bit found;
            found = 0;
            if (held_cnt == 3 && held[0] == LETTER_S && held[1] == LETTER_O &&
                held[2] == LETTER_S) begin
                burst_q.insert(burst_q.size(), SOS_SUB);
                found = 1;
            end else if (held_cnt == 2) begin
                for (int i = 0; i < NUM_PROSIGNS; i++) begin
                    if (!found && PROSIGN_WORDS[i][15:8] == held[0] &&
                        PROSIGN_WORDS[i][7:0] == held[1]) begin
                        burst_q.insert(burst_q.size(), PROSIGN_CODES[i]);
                        found = 1;
                    end
                end
            end
            if (!found) begin
                for (int i = 0; i < held_cnt; i++) burst_q.insert(burst_q.size(), held[i]);
            end
            held_cnt = 0;
        endfunction

        // Notes an accepted input transaction and queues the bytes it releases.
        function void note_item(pws_pkg::item_t it);
            logic [7:0]       b;
            pws_pkg::result_t r;
            b = it.in_byte;
            if (b >= LOWER_A && b <= LOWER_Z) b = b - CASE_OFFSET;
            burst_q.delete();
            if (b == SPACE_BYTE) begin
                close_word();
                burst_q.insert(burst_q.size(), b);
                long_word = 0;
            end else if (long_word) begin
                burst_q.insert(burst_q.size(), b);
            end else if (held_cnt < 3) begin
                held[held_cnt] = b;
                held_cnt++;
            end else begin
                for (int i = 0; i < held_cnt; i++) burst_q.insert(burst_q.size(), held[i]);
                held_cnt = 0;
                burst_q.insert(burst_q.size(), b);
                long_word = 1;
            end
            if (it.message_end) begin
                close_word();
                long_word = 0;
            end
            foreach (burst_q[k]) begin
                r.out_byte        = burst_q[k];
                r.run_last        = (k == burst_q.size() - 1);
                r.out_message_end = r.run_last && it.message_end;
                rewritten_q.insert(rewritten_q.size(), r);
            end
        endfunction

        // Compares one output transaction against the oldest owed byte.
        function void check_result(pws_pkg::result_t got);
            pws_pkg::result_t want;
            if (rewritten_q.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected result byte=%h last=%b end=%b", $realtime,
                             got.out_byte, got.run_last, got.out_message_end);
            end else begin
                want = rewritten_q.pop_front();
                if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
                    got.out_message_end !== want.out_message_end) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: mismatch byte %h/%h last %b/%b end %b/%b (exp/act)",
                                 $realtime, want.out_byte, got.out_byte, want.run_last,
                                 got.run_last, want.out_message_end, got.out_message_end);
                end
            end
        endfunction
    endclass

    prosign_scoreboard sb;

    prosign_word_substituter_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("prosign_word_substituter_unit verification failed");
        $finish;
    end

    task automatic add_byte(input logic [7:0] b, input logic last);
        pws_pkg::item_t it;
        it.in_byte     = b;
        it.message_end = last;
        text_q.insert(text_q.size(), it);
    endtask

    // Randomly lowers an upper-case letter so both cases get exercised.
    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (c >= UPPER_A && c <= UPPER_Z && $urandom_range(0, 1) == 1)
            return c + CASE_OFFSET;
        return c;
    endfunction

    function automatic logic [7:0] any_letter();
        return mixed_case(UPPER_A + 8'($urandom_range(0, 25)));
    endfunction

    // Builds the directed text followed by random words, spaces and message ends.
    task automatic build_text();
        int k;
        int len;
        int sep;
        // Space with nothing held, then SOS closed by a space.
        add_byte(SPACE_BYTE, 0);
        add_byte("s", 0); add_byte("O", 0); add_byte("s", 0); add_byte(SPACE_BYTE, 0);
        // Prosign closed by the message end.
        add_byte("K", 0); add_byte("n", 1);
        // Long word: the fourth byte flushes, the fifth passes straight through.
        add_byte("a", 0); add_byte("B", 0); add_byte("c", 0); add_byte("D", 0);
        add_byte("e", 0); add_byte(SPACE_BYTE, 0);
        // Non-ASCII bytes held and released at the message end.
        add_byte(8'hff, 0); add_byte(8'h80, 1);
        add_byte(8'h00, 1);
        add_byte(SPACE_BYTE, 1);
        // A z at the top of the lower-case range, then bytes just outside it that stay as they are.
        add_byte("z", 0); add_byte(8'h7f, 0); add_byte(8'h60, 0); add_byte(8'h7b, 0);
        add_byte(SPACE_BYTE, 1);
        // Fourth byte that also ends the message.
        add_byte("W", 0); add_byte("x", 0); add_byte("Y", 0); add_byte("v", 1);

        while (text_q.size() < TEXT_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    k = $urandom_range(0, NUM_PROSIGNS - 1);
                    add_byte(mixed_case(PROSIGN_WORDS[k][15:8]), 0);
                    add_byte(mixed_case(PROSIGN_WORDS[k][7:0]), 0);
                end
                3:
                begin
                    add_byte(mixed_case(LETTER_S), 0);
                    add_byte(mixed_case(LETTER_O), 0);
                    add_byte(mixed_case(LETTER_S), 0);
                end
                4, 5:
                begin
                    len = $urandom_range(1, 6);
                    repeat (len) add_byte(any_letter(), 0);
                end
                6:
                begin
                    len = $urandom_range(1, 5);
                    repeat (len) add_byte(8'($urandom_range(0, 255)), 0);
                end
                7:
                begin
                    // Near misses: prosign prefix with a wrong letter, or SO / SOSx.
                    k = $urandom_range(0, NUM_PROSIGNS - 1);
                    if ($urandom_range(0, 1) == 1) begin
                        add_byte(mixed_case(PROSIGN_WORDS[k][15:8]), 0);
                        add_byte(any_letter(), 0);
                    end else begin
                        add_byte(mixed_case(LETTER_S), 0);
                        add_byte(mixed_case(LETTER_O), 0);
                        if ($urandom_range(0, 1) == 1) begin
                            add_byte(mixed_case(LETTER_S), 0);
                            add_byte(any_letter(), 0);
                        end
                    end
                end
                8:
                begin
                    // Prosign followed by a third letter is an ordinary word.
                    k = $urandom_range(0, NUM_PROSIGNS - 1);
                    add_byte(mixed_case(PROSIGN_WORDS[k][15:8]), 0);
                    add_byte(mixed_case(PROSIGN_WORDS[k][7:0]), 0);
                    add_byte(any_letter(), 0);
                end
                default:
                begin
                    add_byte(SPACE_BYTE, 0);
                end
            endcase
            sep = $urandom_range(0, 9);
            if (sep == 0)
                text_q[text_q.size() - 1].message_end = 1'b1;
            else if (sep == 1)
                add_byte(SPACE_BYTE, 1);
            else if (sep == 2)
            begin
                add_byte(SPACE_BYTE, 0);
                add_byte(SPACE_BYTE, 0);
            end else
                add_byte(SPACE_BYTE, 0);
        end
        // Close the last message so every held byte comes out.
        add_byte(SPACE_BYTE, 1);
    endtask

    // Main sequence: reset, send the text with varied pacing, drain, report.
    initial
    begin
        int gap;
        int pressure_start;
        int pause_at;
        int fast_start;
        sb            = new();
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        hold_off_req  = 0;
        no_idle       = 0;
        build_text();
        pressure_start = 100;
        pause_at       = 200;
        fast_start     = 250;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < text_q.size(); i++) begin
            if (i == pressure_start) hold_off_req = 1;
            no_idle = (i >= fast_start && i < fast_start + 40);
            item       <= text_q[i];
            item_valid <= 1'b1;
            do @(posedge clk); while (item_stall);
            sb.note_item(text_q[i]);

            // Pacing before the next transaction.
            if (no_idle || (i >= pressure_start && i < pressure_start + 40))
                gap = 0;
            else
                gap = $urandom_range(0, MAX_IDLE);
            if (i + 1 == pause_at || i + 1 == text_q.size()) gap = (gap == 0) ? 1 : gap;
            if (gap > 0) begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            if (i + 1 == pause_at) begin
                while (sb.pending() != 0) @(posedge clk);
                repeat (SETTLE_CYCLES) @(posedge clk);
            end
        end

        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("prosign_word_substituter_unit verification clean");
        else
            $display("prosign_word_substituter_unit verification failed");
        $finish;
    end

    // Receiver: random stalls per transaction, one long hold-off on request.
    initial
    begin
        int hold;
        result_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req) begin
                hold_off_req = 0;
                hold = HOLD_OFF_LEN;
            end else if (no_idle) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, MAX_IDLE);
            end
            if (hold > 0) begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                result_stall <= 1'b0;
            end
            do @(posedge clk); while (!result_valid);
            sb.check_result(result);
        end
    end

endmodule
